// ===== sv/indexed_array_insert_erase_core_macros.svh =====
// assertion macros for the indexed array insert/erase core
`ifndef INDEXED_ARRAY_INSERT_ERASE_CORE_MACROS_SVH
`define INDEXED_ARRAY_INSERT_ERASE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define IAIE_ASSERT_NOW(label, c, r, ante, cons, msg) \
  label: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define IAIE_ASSERT_NEXT(label, c, r, ante, cons, msg) \
  label: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/iaie_pkg.sv =====
// shared types and constants for the indexed array insert/erase core
package iaie_pkg;

  localparam int DEPTH_DEFAULT       = 16;
  localparam int VALUE_WIDTH_DEFAULT = 32;

  localparam int POS_W   = 8;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_REPLACE = 2'd1,
    ACT_ERASE   = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_PLACE,
    CELL_ERASE,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
  } cell_cmd_t;

  typedef enum logic {
    ST_RUN,
    ST_CLEAR
  } state_t;

endpackage

// ===== sv/indexed_array_insert_erase_core.sv =====
// top level of the indexed array insert/erase core: a chain of entry cells and its control
// insert, replace/append, erase: one request per cycle unless rsp_stall or a clear stalls
// clear of n entries streams n responses (one when empty), then takes requests
// an accepted request's first response is loaded into the output register on the next clock
// rst (synchronous, active high) empties the array and the output register; entries keep data
module indexed_array_insert_erase_core #(
  parameter int DEPTH       = iaie_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = iaie_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    action,
  input  logic [iaie_pkg::POS_W-1:0]    position,
  input  logic [iaie_pkg::WORD_W-1:0]   entry_value,
  // response channel
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          released_valid,
  output logic [iaie_pkg::WORD_W-1:0]   released_word,
  output logic [iaie_pkg::COUNT_W-1:0]  entry_count,
  output logic                          dropped,
  output logic                          last_result
);

  // stored words never need more bits than the 32-bit ports carry
  localparam int STORE_W = (VALUE_WIDTH < iaie_pkg::WORD_W) ? VALUE_WIDTH : iaie_pkg::WORD_W;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);

  iaie_pkg::state_t    state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    left, left_next;     // clear responses still to send after this one
  iaie_pkg::cell_cmd_t cmd;

  logic [STORE_W-1:0]  value;
  logic [STORE_W-1:0]  cell_q [DEPTH];
  logic [STORE_W-1:0]  sel_word;

  logic                out_free;
  logic                take;
  logic                full;
  logic                in_range;
  logic [iaie_pkg::POS_W-1:0] count_pos;

  logic                load;
  logic                ld_released;
  logic [STORE_W-1:0]  ld_word;
  logic [CNT_W-1:0]    ld_count;
  logic                ld_dropped;
  logic                ld_last;

  // masked to the stored width
  assign value = STORE_W'(entry_value);

  // ---------------------------------------------------------------------------
  // chain of cells: each takes from its lower neighbor on insert and from its
  // upper neighbor on erase and on each clear step; the top cell feeds itself
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [STORE_W-1:0] lower_w;
    logic [STORE_W-1:0] upper_w;

    if (i == 0) begin : g_bottom
      assign lower_w = value;
    end else begin : g_lower
      assign lower_w = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign upper_w = cell_q[i];
    end else begin : g_upper
      assign upper_w = cell_q[i+1];
    end

    iaie_cell #(
      .INDEX   (i),
      .STORE_W (STORE_W)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .value (value),
      .lower (lower_w),
      .upper (upper_w),
      .q     (cell_q[i])
    );
  end

  // old word at the addressed entry, used by replace and erase only when in range
  assign sel_word = cell_q[position[IDX_W-1:0]];

  // ---------------------------------------------------------------------------
  // handshake: the output register frees when empty or when it drains this cycle
  // ---------------------------------------------------------------------------
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = !((state == iaie_pkg::ST_RUN) && out_free);
  assign take      = req_valid && !req_stall;

  assign count_pos = iaie_pkg::POS_W'(count);
  assign full      = (count == CNT_W'(DEPTH));
  assign in_range  = (position < count_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iaie_pkg::ST_RUN;
      count <= '0;
      left  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      left  <= left_next;
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    left_next   = left;
    cmd.op      = iaie_pkg::CELL_HOLD;
    cmd.pos     = position;
    load        = 1'b0;
    ld_released = 1'b0;
    ld_word     = '0;
    ld_count    = count;
    ld_dropped  = 1'b0;
    ld_last     = 1'b1;

    unique case (state)
      iaie_pkg::ST_RUN: begin
        if (take) begin
          load = 1'b1;
          unique case (iaie_pkg::action_t'(action))
            iaie_pkg::ACT_INSERT: begin
              if (full) begin
                ld_dropped = 1'b1;
              end else begin
                // position beyond the count clamps to an append
                cmd.op     = iaie_pkg::CELL_INSERT;
                cmd.pos    = (position > count_pos) ? count_pos : position;
                count_next = count + 1'b1;
                ld_count   = count_next;
              end
            end
            iaie_pkg::ACT_REPLACE: begin
              if (in_range) begin
                cmd.op      = iaie_pkg::CELL_PLACE;
                ld_released = 1'b1;
                ld_word     = sel_word;
              end else if (full) begin
                ld_dropped = 1'b1;
              end else begin
                // out of range: append at the count
                cmd.op     = iaie_pkg::CELL_PLACE;
                cmd.pos    = count_pos;
                count_next = count + 1'b1;
                ld_count   = count_next;
              end
            end
            iaie_pkg::ACT_ERASE: begin
              if (in_range) begin
                cmd.op      = iaie_pkg::CELL_ERASE;
                ld_released = 1'b1;
                ld_word     = sel_word;
                count_next  = count - 1'b1;
                ld_count    = count_next;
              end
            end
            iaie_pkg::ACT_CLEAR: begin
              ld_count = '0;
              if (count != '0) begin
                // first entry leaves now, the rest stream out of cell zero
                cmd.op      = iaie_pkg::CELL_SHIFT;
                ld_released = 1'b1;
                ld_word     = cell_q[0];
                ld_last     = (count == CNT_W'(1));
                count_next  = '0;
                left_next   = count - 1'b1;
                if (count != CNT_W'(1)) begin
                  state_next = iaie_pkg::ST_CLEAR;
                end
              end
            end
          endcase
        end
      end
      iaie_pkg::ST_CLEAR: begin
        if (out_free) begin
          load        = 1'b1;
          cmd.op      = iaie_pkg::CELL_SHIFT;
          ld_released = 1'b1;
          ld_word     = cell_q[0];
          ld_count    = '0;
          ld_last     = (left == CNT_W'(1));
          left_next   = left - 1'b1;
          if (left == CNT_W'(1)) begin
            state_next = iaie_pkg::ST_RUN;
          end
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      released_valid <= ld_released;
      released_word  <= iaie_pkg::WORD_W'(ld_word);
      entry_count    <= iaie_pkg::COUNT_W'(ld_count);
      dropped        <= ld_dropped;
      last_result    <= ld_last;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
`include "indexed_array_insert_erase_core_macros.svh"

  `IAIE_ASSERT_NEXT(a_take_gives_rsp, clk, rst, take, rsp_valid, "accepted request without response")
  `IAIE_ASSERT_NOW(a_clear_empty, clk, rst, state == iaie_pkg::ST_CLEAR, count == '0 && left != '0, "clear stream with stale count")
  `IAIE_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH), "count above depth")
  `IAIE_ASSERT_NOW(a_drop_no_release, clk, rst, rsp_valid && dropped, !released_valid && last_result, "dropped response carries a word")

endmodule

// ===== sv/iaie_cell.sv =====
// one storage cell of the shifting entry chain
module iaie_cell #(
  parameter int INDEX   = 0,
  parameter int STORE_W = 32
) (
  input  logic                clk,
  input  iaie_pkg::cell_cmd_t cmd,
  input  logic [STORE_W-1:0]  value,
  input  logic [STORE_W-1:0]  lower,
  input  logic [STORE_W-1:0]  upper,
  output logic [STORE_W-1:0]  q
);

  logic at_pos;
  logic above_pos;

  assign at_pos    = (cmd.pos == iaie_pkg::POS_W'(INDEX));
  assign above_pos = (iaie_pkg::POS_W'(INDEX) > cmd.pos);

  always_ff @(posedge clk) begin
    case (cmd.op)
      iaie_pkg::CELL_INSERT: begin
        if (at_pos) begin
          q <= value;
        end else if (above_pos) begin
          q <= lower;
        end
      end
      iaie_pkg::CELL_PLACE: begin
        if (at_pos) begin
          q <= value;
        end
      end
      iaie_pkg::CELL_ERASE: begin
        if (at_pos || above_pos) begin
          q <= upper;
        end
      end
      iaie_pkg::CELL_SHIFT: q <= upper;
      default: q <= q;
    endcase
  end

endmodule

// ===== tb/indexed_array_insert_erase_core_tb.sv =====
// self-checking testbench for the indexed array insert/erase core
`timescale 1ns / 100ps

module indexed_array_insert_erase_core_tb;

  localparam int DEPTH       = iaie_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_REQS = 435;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 24;

  // one request as the driver sees it: payload plus its idle pattern
  typedef struct {
    iaie_pkg::action_t                act;
    logic [iaie_pkg::POS_W-1:0]       pos;
    logic [iaie_pkg::WORD_W-1:0]      value;
    int                               gap;
    bit                               drain;
  } array_req_t;

  // one response the array owes us
  typedef struct {
    logic                             rel_valid;
    logic [iaie_pkg::WORD_W-1:0]      word;
    logic [iaie_pkg::COUNT_W-1:0]     count;
    logic                             drop;
    logic                             last;
  } outcome_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               req_valid = 1'b0;
  logic                               req_stall;
  logic [1:0]                         action = iaie_pkg::ACT_INSERT;
  logic [iaie_pkg::POS_W-1:0]         position = '0;
  logic [iaie_pkg::WORD_W-1:0]        entry_value = '0;
  logic                               rsp_valid;
  logic                               rsp_stall = 1'b0;
  logic                               released_valid;
  logic [iaie_pkg::WORD_W-1:0]        released_word;
  logic [iaie_pkg::COUNT_W-1:0]       entry_count;
  logic                               dropped;
  logic                               last_result;

  // handshake flags captured at the rising edge, read by the falling-edge drivers
  logic                               req_fire = 1'b0;
  logic                               rsp_fire = 1'b0;

  array_req_t                         pending_reqs[$];
  array_req_t                         staged_req;
  bit                                 staged = 1'b0;
  outcome_t                           owed_outcomes[$];

  // shadow copy of the array contents
  logic [iaie_pkg::WORD_W-1:0]        shadow_words [DEPTH];
  int                                 shadow_fill = 0;

  int                                 rsp_stall_left = 0;
  int                                 rsp_mode = 0;
  int                                 mismatches = 0;
  int                                 reqs_taken = 0;
  int                                 rsps_seen = 0;
  int                                 drops_seen = 0;
  int                                 clears_taken = 0;
  int                                 full_hits = 0;
  int                                 cycle_count = 0;

  indexed_array_insert_erase_core #(
    .DEPTH(DEPTH),
    .VALUE_WIDTH(iaie_pkg::VALUE_WIDTH_DEFAULT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .action(action),
    .position(position),
    .entry_value(entry_value),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .released_valid(released_valid),
    .released_word(released_word),
    .entry_count(entry_count),
    .dropped(dropped),
    .last_result(last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // idle cycles for one request or response: none, occasional, or heavy
  function automatic int idle_cycles(int mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
      default: return $urandom_range(0, 11);
    endcase
  endfunction

  function automatic void owe(logic rel_valid, logic [iaie_pkg::WORD_W-1:0] word, int count,
                              logic drop, logic last);
    owed_outcomes.push_back('{rel_valid, word, iaie_pkg::COUNT_W'(count), drop, last});
  endfunction

  // applies one accepted request to the shadow array and queues what it must return
  function automatic void apply_array_request(iaie_pkg::action_t act,
                                              logic [iaie_pkg::POS_W-1:0] pos,
                                              logic [iaie_pkg::WORD_W-1:0] value);
    int slot;
    int n;
    slot = int'(pos);
    case (act)
      iaie_pkg::ACT_INSERT: begin
        if (shadow_fill >= DEPTH) begin
          owe(1'b0, '0, shadow_fill, 1'b1, 1'b1);
        end else begin
          // position past the end clamps to an append
          if (slot > shadow_fill) slot = shadow_fill;
          for (int i = shadow_fill; i > slot; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[slot] = value;
          shadow_fill++;
          if (shadow_fill == DEPTH) full_hits++;
          owe(1'b0, '0, shadow_fill, 1'b0, 1'b1);
        end
      end
      iaie_pkg::ACT_REPLACE: begin
        if (slot < shadow_fill) begin
          owe(1'b1, shadow_words[slot], shadow_fill, 1'b0, 1'b1);
          shadow_words[slot] = value;
        end else if (shadow_fill >= DEPTH) begin
          owe(1'b0, '0, shadow_fill, 1'b1, 1'b1);
        end else begin
          shadow_words[shadow_fill] = value;
          shadow_fill++;
          if (shadow_fill == DEPTH) full_hits++;
          owe(1'b0, '0, shadow_fill, 1'b0, 1'b1);
        end
      end
      iaie_pkg::ACT_ERASE: begin
        if (slot < shadow_fill) begin
          owe(1'b1, shadow_words[slot], shadow_fill - 1, 1'b0, 1'b1);
          for (int i = slot + 1; i < shadow_fill; i++) shadow_words[i-1] = shadow_words[i];
          shadow_fill--;
        end else begin
          owe(1'b0, '0, shadow_fill, 1'b0, 1'b1);
        end
      end
      default: begin
        clears_taken++;
        n = shadow_fill;
        shadow_fill = 0;
        if (n == 0) owe(1'b0, '0, 0, 1'b0, 1'b1);
        for (int i = 0; i < n; i++) owe(1'b1, shadow_words[i], 0, 1'b0, i == n - 1);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [iaie_pkg::WORD_W-1:0] got,
                                 logic [iaie_pkg::WORD_W-1:0] want);
    $display("%0t ns: mismatch on %s, got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic queue_req(iaie_pkg::action_t act, int pos,
                           logic [iaie_pkg::WORD_W-1:0] value, bit drain);
    pending_reqs.push_back('{act, iaie_pkg::POS_W'(pos), value, idle_cycles(2), drain});
  endtask

  // request driver: holds a presented request until it is taken, then plays out
  // the next request's idle gap and, if asked, waits for the array to go quiet
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (!staged && pending_reqs.size() != 0) begin
        staged_req = pending_reqs.pop_front();
        staged = 1'b1;
      end
      if (!staged) begin
        req_valid <= 1'b0;
      end else if (staged_req.gap > 0) begin
        staged_req.gap = staged_req.gap - 1;
        req_valid <= 1'b0;
      end else if (staged_req.drain && owed_outcomes.size() != 0) begin
        // hold off until every owed response has come back
        req_valid <= 1'b0;
      end else begin
        req_valid   <= 1'b1;
        action      <= staged_req.act;
        position    <= staged_req.pos;
        entry_value <= staged_req.value;
        staged = 1'b0;
      end
    end
  end

  // response side back-pressure, one draw per response, mode changes now and then
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_fire) begin
        if (rsps_seen % 37 == 0) rsp_mode = $urandom_range(0, 2);
        rsp_stall_left = idle_cycles(rsp_mode);
      end
      if (rsp_stall_left > 0) begin
        rsp_stall <= 1'b1;
        rsp_stall_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // monitor: checks each taken response against the oldest owed one, then
  // folds any taken request into the shadow array
  always @(posedge clk) begin
    req_fire <= !rst && req_valid && !req_stall;
    rsp_fire <= !rst && rsp_valid && !rsp_stall;
    if (!rst && rsp_valid && !rsp_stall) begin
      rsps_seen++;
      if (dropped === 1'b1) drops_seen++;
      if (owed_outcomes.size() == 0) begin
        report_mismatch("response with nothing owed", released_word, '0);
      end else begin
        if (released_valid !== owed_outcomes[0].rel_valid)
          report_mismatch("released_valid", iaie_pkg::WORD_W'(released_valid),
                          iaie_pkg::WORD_W'(owed_outcomes[0].rel_valid));
        if (released_word !== owed_outcomes[0].word)
          report_mismatch("released_word", released_word, owed_outcomes[0].word);
        if (entry_count !== owed_outcomes[0].count)
          report_mismatch("entry_count", iaie_pkg::WORD_W'(entry_count),
                          iaie_pkg::WORD_W'(owed_outcomes[0].count));
        if (dropped !== owed_outcomes[0].drop)
          report_mismatch("dropped", iaie_pkg::WORD_W'(dropped),
                          iaie_pkg::WORD_W'(owed_outcomes[0].drop));
        if (last_result !== owed_outcomes[0].last)
          report_mismatch("last_result", iaie_pkg::WORD_W'(last_result),
                          iaie_pkg::WORD_W'(owed_outcomes[0].last));
        void'(owed_outcomes.pop_front());
      end
    end
    if (!rst && req_valid && !req_stall) begin
      reqs_taken++;
      apply_array_request(iaie_pkg::action_t'(action), position, entry_value);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d responses owed",
               cycle_count, owed_outcomes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int bias;
    int gap_mode;
    int roll;
    array_req_t r;

    // directed: empty-array corner cases first
    queue_req(iaie_pkg::ACT_CLEAR, 0, 32'h0, 1'b0);            // clear of an empty array
    queue_req(iaie_pkg::ACT_ERASE, 255, 32'h0, 1'b0);          // erase past the end
    queue_req(iaie_pkg::ACT_REPLACE, 200, 32'h0, 1'b0);        // replace past the end appends
    queue_req(iaie_pkg::ACT_INSERT, 255, 32'hFFFF_FFFF, 1'b0); // insert past the end clamps
    queue_req(iaie_pkg::ACT_INSERT, 0, 32'h1234_5678, 1'b0);
    queue_req(iaie_pkg::ACT_REPLACE, 1, 32'hA5A5_A5A5, 1'b0);  // replace in range, old word back
    queue_req(iaie_pkg::ACT_ERASE, 1, 32'h0, 1'b0);
    queue_req(iaie_pkg::ACT_ERASE, 2, 32'h0, 1'b0);            // erase just past the end
    // fill to the top from two entries
    for (int k = 0; k < DEPTH - 2; k++) queue_req(iaie_pkg::ACT_INSERT, k % 3, $urandom, 1'b0);
    queue_req(iaie_pkg::ACT_INSERT, 3, 32'h5A5A_5A5A, 1'b0);      // full: insert dropped
    queue_req(iaie_pkg::ACT_REPLACE, DEPTH, 32'h0F0F_0F0F, 1'b0); // full: append dropped
    queue_req(iaie_pkg::ACT_CLEAR, 0, 32'h0, 1'b1);  // clear of a full array, after a drain

    // random: phases that grow, shrink or mix the array
    bias = 2;
    gap_mode = 0;
    for (int k = 0; k < RANDOM_REQS; k++) begin
      if (k % 40 == 0) begin
        bias = $urandom_range(0, 2);
        gap_mode = $urandom_range(0, 2);
      end
      roll = $urandom_range(0, 99);
      case (bias)
        0: r.act = (roll < 45) ? iaie_pkg::ACT_INSERT : (roll < 80) ? iaie_pkg::ACT_REPLACE :
                   (roll < 96) ? iaie_pkg::ACT_ERASE : iaie_pkg::ACT_CLEAR;
        1: r.act = (roll < 20) ? iaie_pkg::ACT_INSERT : (roll < 35) ? iaie_pkg::ACT_REPLACE :
                   (roll < 95) ? iaie_pkg::ACT_ERASE : iaie_pkg::ACT_CLEAR;
        default: r.act = (roll < 30) ? iaie_pkg::ACT_INSERT :
                         (roll < 55) ? iaie_pkg::ACT_REPLACE :
                         (roll < 91) ? iaie_pkg::ACT_ERASE : iaie_pkg::ACT_CLEAR;
      endcase
      // mostly positions near the live range, now and then anything
      r.pos = ($urandom_range(0, 3) == 0) ? iaie_pkg::POS_W'($urandom_range(0, 255)) :
                                            iaie_pkg::POS_W'($urandom_range(0, DEPTH + 1));
      roll = $urandom_range(0, 15);
      r.value = (roll == 0) ? '0 : (roll == 1) ? '1 : iaie_pkg::WORD_W'($urandom);
      r.gap = idle_cycles(gap_mode);
      r.drain = ($urandom_range(0, 49) == 0);
      pending_reqs.push_back(r);
    end

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // all requests handed over, then all owed responses back
    while (pending_reqs.size() != 0 || staged || req_valid) @(posedge clk);
    while (owed_outcomes.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("run covered %0d requests and %0d responses, %0d clears",
             reqs_taken, rsps_seen, clears_taken);
    $display("array filled to the top %0d times, %0d requests dropped as full",
             full_hits, drops_seen);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
